>>> rtl/core/fbm_pkg.sv
// ----------------------------------------------------------------------------
// fbm_pkg: shared types and constants of the forward bracket matcher
// Character codes, result status codes, register indexes and the small
// structs that pass between the scan datapath and the judge logic.
// ----------------------------------------------------------------------------
`default_nettype none

package fbm_pkg;

    // Character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    // Result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_FUNC_END  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_OPEN_CHAR        = 3'd0;
    localparam logic [2:0] CFG_CLOSE_CHAR       = 3'd1;
    localparam logic [2:0] CFG_START_DEPTH      = 3'd2;
    localparam logic [2:0] CFG_START_IN_COMMENT = 3'd3;
    localparam logic [2:0] CFG_CODE_MODE        = 3'd4;

    // Registers that act on every character
    typedef struct packed {
        logic [7:0] open_char;
        logic [7:0] close_char;
        logic       code_mode;
    } fbm_cfg_t;

    // Comment tracking flags
    typedef struct packed {
        logic in_block_comment;
        logic skip_line;
    } fbm_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/fbm_judge.sv
// ----------------------------------------------------------------------------
// fbm_judge: bracket and comment decision for one character
// Given the character, one character of lookahead and the scan state,
// updates depth and comment flags and flags a found or function-end result.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_judge #(
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                   en,
    input  wire fbm_pkg::fbm_cfg_t      cfg,
    input  wire logic [7:0]             cur_char,
    input  wire logic                   col_zero,
    input  wire logic                   has_next,
    input  wire logic [7:0]             next_char,
    input  wire fbm_pkg::fbm_flags_t    flags_in,
    input  wire logic [DEPTH_BITS-1:0]  depth_in,
    output fbm_pkg::fbm_flags_t         flags_out,
    output logic [DEPTH_BITS-1:0]       depth_out,
    output logic                        decided,
    output logic [1:0]                  status
);
    import fbm_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    logic nslash;
    logic nstar;
    logic nquote;

    assign nslash = has_next && (next_char == CH_SLASH);
    assign nstar  = has_next && (next_char == CH_STAR);
    assign nquote = has_next && (next_char == CH_QUOTE);

    always_comb begin
        flags_out = flags_in;
        depth_out = depth_in;
        decided   = 1'b0;
        status    = ST_FOUND;
        if (!en || flags_in.skip_line) begin
            // nothing counts
        end else if (cfg.code_mode && cur_char == CH_SLASH && nslash) begin
            flags_out.skip_line = 1'b1;
        end else if (flags_in.in_block_comment) begin
            if (cur_char == CH_STAR && nslash) begin
                flags_out.in_block_comment = 1'b0;
            end
        end else if (cfg.code_mode && cur_char == CH_SLASH && nstar) begin
            flags_out.in_block_comment = 1'b1;
        end else if (cur_char == cfg.close_char && !nquote) begin
            if (depth_in == '0) begin
                decided = 1'b1;
                status  = ST_FOUND;
            end else if (col_zero && cfg.close_char == CH_RCURLY && cfg.code_mode) begin
                decided = 1'b1;
                status  = ST_FUNC_END;
            end else begin
                depth_out = depth_in - 1'b1;
            end
        end else if (cur_char == cfg.open_char && !nquote) begin
            if (depth_in != DEPTH_MAX) begin
                depth_out = depth_in + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/forward_bracket_matcher.sv
// ----------------------------------------------------------------------------
// forward_bracket_matcher: forward scan for the matching close bracket
// Takes one text character per transfer and reports found, function end or
// not found with the line offset and column of the deciding character.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_ch, s_line_end, s_last_item
//  m_        out        m_valid / m_ready    m_status, m_line_offset, m_column
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One character per cycle sustained while no waiting result stalls the scan;
//  a result passes from the character transfer that decides it through the
//  input register, then the judge logic into the result register.
//  Reset loads the register defaults and arms a new search; no clearing pass.
//  A waiting result stalls the scan only once the input register is full.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module forward_bracket_matcher #(
    parameter int MAX_LINE_CHARS = 4096,
    parameter int DEPTH_BITS     = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_line_end,
    input  wire logic        s_last_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_line_offset,
    output logic [11:0]      m_column,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import fbm_pkg::*;

    localparam int COL_BITS = ($clog2(MAX_LINE_CHARS) < 12) ? $clog2(MAX_LINE_CHARS) : 12;
    localparam int COL_MAX_INT = ((MAX_LINE_CHARS - 1) < 4095) ? (MAX_LINE_CHARS - 1) : 4095;
    localparam logic [COL_BITS-1:0] COL_MAX = COL_MAX_INT[COL_BITS-1:0];
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    // Configuration
    fbm_cfg_t    cfg_reg;
    logic [15:0] start_depth_reg;
    logic        start_in_comment_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_char    <= 8'd123;
            cfg_reg.close_char   <= 8'd125;
            cfg_reg.code_mode    <= 1'b1;
            start_depth_reg      <= 16'd0;
            start_in_comment_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OPEN_CHAR:        cfg_reg.open_char    <= cfg_data[7:0];
                CFG_CLOSE_CHAR:       cfg_reg.close_char   <= cfg_data[7:0];
                CFG_START_DEPTH:      start_depth_reg      <= cfg_data;
                CFG_START_IN_COMMENT: start_in_comment_reg <= cfg_data[0];
                CFG_CODE_MODE:        cfg_reg.code_mode    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Start depth clamped to the depth range
    logic [DEPTH_BITS-1:0] start_depth_clamped;
    generate
        if (DEPTH_BITS >= 16) begin : g_depth_wide
            assign start_depth_clamped = DEPTH_BITS'(start_depth_reg);
        end else begin : g_depth_narrow
            assign start_depth_clamped = (|start_depth_reg[15:DEPTH_BITS]) ? '1
                                       : start_depth_reg[DEPTH_BITS-1:0];
        end
    endgenerate

    // Input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       line_end_reg;
    logic       last_item_reg;
    logic       proc_en;

    assign proc_en = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || proc_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg        <= s_ch;
            line_end_reg  <= s_line_end;
            last_item_reg <= s_last_item;
        end
    end

    // Scan state
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    fbm_flags_t            flags_reg, flags_next;
    logic [7:0]            held_char_reg, held_char_next;
    logic                  held_valid_reg, held_valid_next;
    logic [COL_BITS-1:0]   held_col_reg, held_col_next;
    logic [15:0]           line_reg, line_next;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic                  done_reg, done_next;
    logic                  fresh_reg, fresh_next;

    // State seen by this character, with a new search loaded
    logic [DEPTH_BITS-1:0] depth_eff;
    fbm_flags_t            flags_eff;
    logic                  held_valid_eff;
    logic [15:0]           line_eff;
    logic [COL_BITS-1:0]   col_eff;
    logic                  done_eff;

    always_comb begin
        if (fresh_reg) begin
            depth_eff                  = start_depth_clamped;
            flags_eff.in_block_comment = start_in_comment_reg;
            flags_eff.skip_line        = 1'b0;
            held_valid_eff             = 1'b0;
            line_eff                   = 16'd0;
            col_eff                    = '0;
            done_eff                   = 1'b0;
        end else begin
            depth_eff      = depth_reg;
            flags_eff      = flags_reg;
            held_valid_eff = held_valid_reg;
            line_eff       = line_reg;
            col_eff        = col_reg;
            done_eff       = done_reg;
        end
    end

    logic                  ends_here;
    fbm_flags_t            flags_a, flags_b;
    logic [DEPTH_BITS-1:0] depth_a, depth_b;
    logic                  dec_a, dec_b;
    logic [1:0]            st_a, st_b;

    assign ends_here = line_end_reg || last_item_reg;

    // Held character, judged with this one as lookahead
    fbm_judge #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_judge_held (
        .en        (held_valid_eff && !done_eff),
        .cfg       (cfg_reg),
        .cur_char  (held_char_reg),
        .col_zero  (held_col_reg == '0),
        .has_next  (1'b1),
        .next_char (ch_reg),
        .flags_in  (flags_eff),
        .depth_in  (depth_eff),
        .flags_out (flags_a),
        .depth_out (depth_a),
        .decided   (dec_a),
        .status    (st_a)
    );

    // This character when nothing follows it
    fbm_judge #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_judge_last (
        .en        (!done_eff && !dec_a && ends_here),
        .cfg       (cfg_reg),
        .cur_char  (ch_reg),
        .col_zero  (col_eff == '0),
        .has_next  (1'b0),
        .next_char (8'd0),
        .flags_in  (flags_a),
        .depth_in  (depth_a),
        .flags_out (flags_b),
        .depth_out (depth_b),
        .decided   (dec_b),
        .status    (st_b)
    );

    logic                fire;
    logic [1:0]          res_status;
    logic [COL_BITS-1:0] res_col;

    always_comb begin
        depth_next      = depth_eff;
        flags_next      = flags_eff;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_eff;
        held_col_next   = held_col_reg;
        line_next       = line_eff;
        col_next        = col_eff;
        done_next       = done_eff;
        fresh_next      = 1'b0;
        fire            = 1'b0;
        res_status      = ST_NOT_FOUND;
        res_col         = col_eff;
        if (done_eff) begin
            // drop items up to the end of the range
            fresh_next = last_item_reg;
        end else begin
            depth_next = depth_b;
            flags_next = flags_b;
            if (!dec_a && !ends_here) begin
                held_char_next  = ch_reg;
                held_col_next   = col_eff;
                held_valid_next = 1'b1;
            end else begin
                held_valid_next = 1'b0;
            end
            if (line_end_reg) begin
                if (line_eff != LINE_MAX) begin
                    line_next = line_eff + 16'd1;
                end
                col_next             = '0;
                flags_next.skip_line = 1'b0;
            end else if (col_eff != COL_MAX) begin
                col_next = col_eff + 1'b1;
            end
            if (dec_a) begin
                fire       = 1'b1;
                res_status = st_a;
                res_col    = held_col_reg;
            end else if (dec_b) begin
                fire       = 1'b1;
                res_status = st_b;
            end else if (last_item_reg) begin
                fire = 1'b1;
            end
            if (fire) begin
                done_next  = 1'b1;
                fresh_next = last_item_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= '0;
            flags_reg      <= '0;
            held_char_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            held_col_reg   <= '0;
            line_reg       <= 16'd0;
            col_reg        <= '0;
            done_reg       <= 1'b0;
            fresh_reg      <= 1'b1;
        end else if (proc_en) begin
            depth_reg      <= depth_next;
            flags_reg      <= flags_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            held_col_reg   <= held_col_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            done_reg       <= done_next;
            fresh_reg      <= fresh_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (proc_en && fire) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en && fire) begin
            m_status      <= res_status;
            m_line_offset <= line_eff;
            m_column      <= 12'(res_col);
        end
    end

    // Checks
    a_fresh_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg |-> !held_valid_reg)
        else $error("held character survives into a new search");

    a_done_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !held_valid_reg)
        else $error("held character left after a result");

    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && fire) |=> m_valid)
        else $error("result not presented");

    a_done_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && fire && !last_item_reg) |=> (done_reg && !fresh_reg))
        else $error("search not closed after a result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

>>> bench/tb_forward_bracket_matcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_forward_bracket_matcher: self-checking bench for the forward bracket matcher
// Streams searches of text characters through the valid/ready input, keeps a
// cycle-free model of the scan per transfer and compares every result field
// against it. Settings change between searches over the configuration port.
// ----------------------------------------------------------------------------

import fbm_pkg::*;

typedef struct packed {
    logic [1:0]  status;
    logic [15:0] line_offset;
    logic [11:0] column;
} match_result_t;

// Tracks the scan state per accepted character and holds the results due.
class match_tracker;
    logic [7:0]    open_c, close_c;
    logic [15:0]   start_d;
    bit            start_cmt, code_on;
    logic [15:0]   depth, line_cnt;
    logic [11:0]   held_col, col_cnt;
    logic [7:0]    held_c;
    bit            in_cmt, skip_line, held_ok, done, fresh;
    match_result_t pending[$];
    int            errors;

    function void clear();
        open_c    = 8'h7B;
        close_c   = 8'h7D;
        start_d   = 16'd0;
        start_cmt = 1'b0;
        code_on   = 1'b1;
        depth     = 16'd0;
        line_cnt  = 16'd0;
        col_cnt   = 12'd0;
        held_col  = 12'd0;
        held_c    = 8'h00;
        in_cmt    = 1'b0;
        skip_line = 1'b0;
        held_ok   = 1'b0;
        done      = 1'b0;
        fresh     = 1'b1;
        errors    = 0;
        pending.delete();
    endfunction

    function void load_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            CFG_OPEN_CHAR:        open_c    = data[7:0];
            CFG_CLOSE_CHAR:       close_c   = data[7:0];
            CFG_START_DEPTH:      start_d   = data;
            CFG_START_IN_COMMENT: start_cmt = data[0];
            CFG_CODE_MODE:        code_on   = data[0];
            default: ;
        endcase
    endfunction

    // Decide on one character given its follower; 1 when the search ends here.
    function bit judge(input logic [7:0] c, input logic [11:0] col, input bit has_next,
                       input logic [7:0] nx, output logic [1:0] st);
        bit nslash, nstar, nquote;
        nslash = has_next && (nx == CH_SLASH);
        nstar  = has_next && (nx == CH_STAR);
        nquote = has_next && (nx == CH_QUOTE);
        st = ST_NOT_FOUND;
        if (skip_line)
            return 1'b0;
        if (code_on && c == CH_SLASH && nslash) begin
            skip_line = 1'b1;
            return 1'b0;
        end
        if (in_cmt) begin
            if (c == CH_STAR && nslash)
                in_cmt = 1'b0;
            return 1'b0;
        end
        if (code_on && c == CH_SLASH && nstar) begin
            in_cmt = 1'b1;
            return 1'b0;
        end
        if (c == close_c && !nquote) begin
            if (depth == 16'd0) begin
                st = ST_FOUND;
                return 1'b1;
            end
            if (col == 12'd0 && close_c == CH_RCURLY && code_on) begin
                st = ST_FUNC_END;
                return 1'b1;
            end
            depth = depth - 16'd1;
            return 1'b0;
        end
        // saturate the depth at all ones
        if (c == open_c && !nquote && depth != 16'hFFFF)
            depth = depth + 16'd1;
        return 1'b0;
    endfunction

    // Advance on one accepted character; 0 when the block ignores it.
    function bit note_char(logic [7:0] c, bit le, bit li);
        logic [11:0]   col, rcol;
        logic [15:0]   lin;
        logic [1:0]    st;
        bit            hit;
        match_result_t r;
        if (fresh) begin
            depth     = start_d;
            in_cmt    = start_cmt;
            skip_line = 1'b0;
            held_c    = 8'h00;
            held_ok   = 1'b0;
            held_col  = 12'd0;
            line_cnt  = 16'd0;
            col_cnt   = 12'd0;
            done      = 1'b0;
            fresh     = 1'b0;
        end
        if (done) begin
            if (li)
                fresh = 1'b1;
            return 1'b0;
        end
        col  = col_cnt;
        lin  = line_cnt;
        hit  = 1'b0;
        rcol = 12'd0;
        st   = ST_NOT_FOUND;
        if (held_ok) begin
            hit     = judge(held_c, held_col, 1'b1, c, st);
            rcol    = held_col;
            held_ok = 1'b0;
        end
        if (!hit) begin
            if (le || li) begin
                hit  = judge(c, col, 1'b0, 8'h00, st);
                rcol = col;
            end else begin
                held_c   = c;
                held_col = col;
                held_ok  = 1'b1;
            end
        end
        if (le) begin
            if (line_cnt != 16'hFFFF)
                line_cnt = line_cnt + 16'd1;
            col_cnt   = 12'd0;
            skip_line = 1'b0;
        end else if (col_cnt != 12'hFFF) begin
            col_cnt = col_cnt + 12'd1;
        end
        if (!hit && li) begin
            hit  = 1'b1;
            st   = ST_NOT_FOUND;
            rcol = col;
        end
        if (hit) begin
            r.status      = st;
            r.line_offset = lin;
            r.column      = rcol;
            pending.push_back(r);
            done = 1'b1;
            if (li)
                fresh = 1'b1;
        end
        return 1'b1;
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [1:0] st, logic [15:0] lo, logic [11:0] col);
        match_result_t w;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result status %0d line %0d column %0d", st, lo, col));
            return;
        end
        w = pending.pop_front();
        if (st !== w.status)
            report($sformatf("status %0d, want %0d", st, w.status));
        if (lo !== w.line_offset)
            report($sformatf("line_offset %0d, want %0d", lo, w.line_offset));
        if (col !== w.column)
            report($sformatf("column %0d, want %0d", col, w.column));
    endtask

    task flush_leftovers();
        match_result_t w;
        while (pending.size() != 0) begin
            w = pending.pop_front();
            report($sformatf("missing result status %0d line %0d column %0d",
                             w.status, w.line_offset, w.column));
        end
    endtask
endclass

module tb_forward_bracket_matcher;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 300;
    localparam int ITEM_TARGET  = 1100;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch          = 8'h00;
    logic        s_line_end    = 1'b0;
    logic        s_last_item   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_line_offset;
    logic [11:0] m_column;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = 3'd0;
    logic [15:0] cfg_data      = 16'd0;

    match_tracker scan;
    bit           idle_on  = 1'b0;
    bit           hold_req = 1'b0;
    int           hold_left  = 0;
    int           burst_left = 0;
    int           cycles     = 0;
    int           sent_items = 0;

    forward_bracket_matcher DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_line_end    (s_line_end),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_line_offset (m_line_offset),
        .m_column      (m_column),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_forward_bracket_matcher: errors");
            $finish;
        end
    end

    // Result side: long hold on request, otherwise random stall bursts while idle_on is set.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scan.check_result(m_status, m_line_offset, m_column);
    end

    task automatic send_char(input logic [7:0] c, input bit le, input bit li);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_ch        <= c;
        s_line_end  <= le;
        s_last_item <= li;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        void'(scan.note_char(c, le, li));
        sent_items++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Hold the input until every result is back, then let the pipeline settle.
    task automatic drain();
        stop_sending();
        while (scan.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        scan.load_reg(idx, data);
    endtask

    // Upper data bits are don't-care for the narrow registers; fill them randomly.
    task automatic apply_setup(input logic [7:0] oc, input logic [7:0] cc,
                               input logic [15:0] sd, input bit cm, input bit code);
        logic [7:0]  junk8;
        logic [14:0] junk15;
        logic [2:0]  bad_idx;
        junk8 = 8'($urandom_range(0, 255));
        cfg_write(CFG_OPEN_CHAR, {junk8, oc});
        junk8 = 8'($urandom_range(0, 255));
        cfg_write(CFG_CLOSE_CHAR, {junk8, cc});
        cfg_write(CFG_START_DEPTH, sd);
        junk15 = 15'($urandom_range(0, 32767));
        cfg_write(CFG_START_IN_COMMENT, {junk15, cm});
        junk15 = 15'($urandom_range(0, 32767));
        cfg_write(CFG_CODE_MODE, {junk15, code});
        if ($urandom_range(0, 2) == 0) begin
            bad_idx = CFG_CODE_MODE + 3'd1 + 3'($urandom_range(0, 2));
            cfg_write(bad_idx, 16'($urandom_range(0, 65535)));
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return scan.open_c;
        else if (r < 8)
            return scan.close_c;
        else if (r < 10)
            return CH_SLASH;
        else if (r < 11)
            return CH_STAR;
        else if (r < 12)
            return CH_QUOTE;
        else if (r < 13)
            return CH_RCURLY;
        else if (r < 14)
            return 8'h7B;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_search(input int len, input bit noise);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = noise ? 8'($urandom_range(0, 255)) : pick_char();
            send_char(c, $urandom_range(0, 5) == 0, i == len - 1);
        end
    endtask

    task automatic random_setup();
        logic [7:0]  oc, cc;
        logic [15:0] sd;
        int          r;
        r = $urandom_range(0, 5);
        case (r)
            0: begin oc = 8'h7B; cc = 8'h7D; end
            1: begin oc = 8'h28; cc = 8'h29; end
            2: begin oc = 8'h5B; cc = 8'h5D; end
            3: begin oc = 8'h3C; cc = 8'h3E; end
            4: begin oc = 8'($urandom_range(0, 255)); cc = oc; end
            default: begin
                oc = 8'($urandom_range(0, 255));
                cc = 8'($urandom_range(0, 255));
            end
        endcase
        r = $urandom_range(0, 9);
        if (r < 6)
            sd = 16'($urandom_range(0, 2));
        else if (r < 9)
            sd = 16'($urandom_range(3, 8));
        else
            sd = 16'($urandom_range(0, 65535));
        apply_setup(oc, cc, sd, $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
    endtask

    initial begin
        int phase_start;
        int phase;
        scan = new();
        scan.clear();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed searches under the reset settings.
        idle_on = 1'b1;
        send_char(CH_RCURLY, 1'b0, 1'b1);
        send_char(8'h7B, 1'b1, 1'b0);
        send_char(CH_RCURLY, 1'b0, 1'b1);
        send_char(CH_RCURLY, 1'b0, 1'b0);
        send_char(CH_QUOTE, 1'b0, 1'b1);
        send_char(CH_SLASH, 1'b0, 1'b0);
        send_char(CH_SLASH, 1'b0, 1'b0);
        send_char(CH_RCURLY, 1'b1, 1'b0);
        send_char(CH_RCURLY, 1'b0, 1'b1);
        send_char(CH_SLASH, 1'b0, 1'b0);
        send_char(CH_STAR, 1'b0, 1'b0);
        send_char(CH_RCURLY, 1'b0, 1'b0);
        send_char(CH_STAR, 1'b0, 1'b0);
        send_char(CH_SLASH, 1'b0, 1'b0);
        send_char(CH_RCURLY, 1'b0, 1'b1);
        send_char(8'h00, 1'b0, 1'b0);
        send_char(8'hFF, 1'b1, 1'b1);
        drain();

        // Extreme settings.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_setup(8'h00, 8'hFF, 16'd0, 1'b0, 1'b0);
                1: apply_setup(8'hFF, 8'h00, 16'hFFFF, 1'b1, 1'b1);
                2: apply_setup(8'h28, 8'h29, 16'd0, 1'b1, 1'b1);
                3: apply_setup(CH_RCURLY, CH_RCURLY, 16'd2, 1'b0, 1'b1);
                default: apply_setup(8'h7B, 8'h7D, 16'd0, 1'b0, 1'b0);
            endcase
            for (int s = 0; s < 8; s++)
                send_search($urandom_range(1, 20), $urandom_range(0, 7) == 0);
            drain();
        end

        // Random settings; one phase starves the result side to back up the input.
        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            random_setup();
            idle_on = (sent_items < ITEM_TARGET - 150);
            phase_start = sent_items;
            if (phase == 2) begin
                hold_req = 1'b1;
                while (sent_items - phase_start < 60)
                    send_search($urandom_range(1, 3), 1'b0);
            end else begin
                while (sent_items - phase_start < 60)
                    send_search($urandom_range(1, 30), $urandom_range(0, 9) == 0);
            end
            drain();
            phase++;
        end

        stop_sending();
        while (scan.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES * 4) @(posedge aclk);
        scan.flush_leftovers();
        if (scan.errors == 0) begin
            $display("tb_forward_bracket_matcher: clean");
        end else begin
            $display("tb_forward_bracket_matcher: errors");
        end
        $finish;
    end

endmodule
